// ===== src/ttst_pkg.sv =====
package ttst_pkg;

    // Field widths of the input and result words.
    localparam int OP_W     = 1;
    localparam int PLATE_W  = 64;
    localparam int TIME_W   = 17;
    localparam int LEN_W    = 17;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;
    localparam int SECS_W   = 17;
    localparam int SPEED_W  = 24;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 56;

    localparam int TABLE_DEPTH_DEF = 128;

    // Length times 36 plus half the seconds never needs more than 23 bits.
    localparam int DIVIDEND_W = 23;

    localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(1000);
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACCEPT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EARLY   = 3'd4;

    // Event kinds carried in s_tuser.
    localparam logic OP_ENTER = 1'b0;
    localparam logic OP_LEAVE = 1'b1;

    // Status returned by the divider to its sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== src/ttst_divider.sv =====
module ttst_divider #(
    parameter int NW = ttst_pkg::DIVIDEND_W,
    parameter int DW = ttst_pkg::SECS_W
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [NW-1:0]          dividend,
    input  logic [DW-1:0]          divisor,
    output logic [NW-1:0]          quotient,
    output ttst_pkg::div_status_t  status
);
    import ttst_pkg::*;

    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      shifted;
    logic             ge;

    // One restoring step per cycle: shift in the next dividend bit and
    // subtract the divisor when it fits.
    always_comb begin
        shifted  = {rem_reg, quo_reg[NW-1]};
        ge       = (shifted >= {1'b0, dsr_reg});
        rem_next = ge ? DW'(shifted - {1'b0, dsr_reg}) : DW'(shifted);
        quo_next = {quo_reg[NW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== src/tunnel_transit_speed_table.sv =====
// Tunnel transit speed table.
//
// The s_ channel carries one event word per vehicle: s_tuser gives the kind
// (enter or leave), s_tdata the plate key and the event time. The m_ channel
// returns exactly one result word per event: m_tuser carries the status,
// m_tdata the slot, transit seconds, speed and the saturation flag. The
// tunnel length is written through cfg_wr_en and cfg_wr_data while idle.
//
// An entry event goes from acceptance to S_RESP, which loads the output
// register once it is free. A leave event on an empty table does the same;
// otherwise it walks the record table one slot per cycle from the oldest
// record through the registered memory read port, and a match that needs a
// speed then runs the restoring one-bit-per-cycle divider. s_tready returns
// in the same cycle as a result enters the output register, so a new event
// is taken only after the result of the last one is in that register.
//
// Reset clears the record count and the sequencer and sets the length to
// 1000 m; the table contents are never read before being written. A result
// waits in the output register while the receiver stalls; the next event is
// still accepted, and its result is held until the output register is free.
module tunnel_transit_speed_table #(
    parameter int TABLE_DEPTH = ttst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: tunnel length in metres.
    input  logic                             cfg_wr_en,
    input  logic [ttst_pkg::LEN_W-1:0]       cfg_wr_data,
    // Event input. tdata: plate_key [63:0], time_seconds [80:64], zero pad.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ttst_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: operation [0].
    input  logic [ttst_pkg::OP_W-1:0]        s_tuser,
    // Result output. tdata: slot_index [6:0], seconds_in_tunnel [23:7],
    // speed_tenths_kmh [47:24], speed_saturated [48], zero pad.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ttst_pkg::M_TDATA_W-1:0]   m_tdata,
    // tuser: status [2:0].
    output logic [ttst_pkg::STATUS_W-1:0]    m_tuser
);
    import ttst_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]          state_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [CW-1:0]       count_reg;

    // Record table, one write and one registered read per cycle.
    logic [PLATE_W-1:0]  plate_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]   time_mem  [TABLE_DEPTH];
    logic [PLATE_W-1:0]  plate_rd_reg;
    logic [TIME_W-1:0]   time_rd_reg;

    // Captured event.
    logic [PLATE_W-1:0]  plate_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   entry_reg;

    // Scan pipeline: address presented now, and the slot whose data is
    // being compared.
    logic [IW-1:0]       scan_idx_reg;
    logic [IW-1:0]       cmp_idx_reg;
    logic                cmp_valid_reg;
    logic [IW-1:0]       last_idx;

    // Pending result and output register.
    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [SECS_W-1:0]   res_secs_reg;
    logic [SPEED_W-1:0]  res_speed_reg;
    logic                res_sat_reg;
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic [SECS_W-1:0]   m_secs_reg;
    logic [SPEED_W-1:0]  m_speed_reg;
    logic                m_sat_reg;

    logic                in_fire;
    logic                in_op;
    logic [PLATE_W-1:0]  in_plate;
    logic [TIME_W-1:0]   in_time;
    logic                table_full;
    logic                wr_en;
    logic                out_free;
    logic                plate_hit;
    logic [SECS_W-1:0]   secs_diff;
    logic                early;
    logic [DIVIDEND_W-1:0] dividend;
    logic                div_start;
    logic [DIVIDEND_W-1:0] quotient;
    div_status_t         div_stat;

    assign in_op      = s_tuser[0];
    assign in_plate   = s_tdata[PLATE_W-1:0];
    assign in_time    = s_tdata[PLATE_W +: TIME_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));
    assign wr_en      = in_fire && (in_op == OP_ENTER) && !table_full;
    assign last_idx   = IW'(count_reg - 1'b1);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign plate_hit  = cmp_valid_reg && (plate_rd_reg == plate_reg);

    // Transit time and the rounded speed dividend: length * 36 is formed as
    // length * 32 + length * 4, and half the seconds gives round-to-nearest.
    assign early     = (time_reg < entry_reg);
    assign secs_diff = SECS_W'(time_reg - entry_reg);
    assign dividend  = (DIVIDEND_W'(len_reg) << 5) + (DIVIDEND_W'(len_reg) << 2)
                     + DIVIDEND_W'(secs_diff >> 1);
    assign div_start = (state_reg == S_CALC) && !early && (secs_diff != '0);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            plate_mem[count_reg[IW-1:0]] <= in_plate;
            time_mem[count_reg[IW-1:0]]  <= in_time;
        end
        if (state_reg == S_SCAN) begin
            plate_rd_reg <= plate_mem[scan_idx_reg];
            time_rd_reg  <= time_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            len_reg <= cfg_wr_data;
        end
    end

    ttst_divider #(
        .NW (DIVIDEND_W),
        .DW (SECS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (secs_diff),
        .quotient (quotient),
        .status   (div_stat)
    );

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        plate_reg      <= in_plate;
                        time_reg       <= in_time;
                        res_status_reg <= ST_UNKNOWN;
                        res_slot_reg   <= '0;
                        res_secs_reg   <= '0;
                        res_speed_reg  <= '0;
                        res_sat_reg    <= 1'b0;
                        scan_idx_reg   <= '0;
                        cmp_valid_reg  <= 1'b0;
                        if (in_op == OP_ENTER) begin
                            state_reg <= S_RESP;
                            if (table_full) begin
                                res_status_reg <= ST_FULL;
                            end else begin
                                res_status_reg <= ST_STORED;
                                res_slot_reg   <= SLOT_W'(count_reg);
                                count_reg      <= count_reg + 1'b1;
                            end
                        end else if (count_reg == '0) begin
                            state_reg <= S_RESP;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    cmp_valid_reg <= 1'b1;
                    cmp_idx_reg   <= scan_idx_reg;
                    if (scan_idx_reg != last_idx) begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (plate_hit) begin
                        entry_reg    <= time_rd_reg;
                        res_slot_reg <= SLOT_W'(cmp_idx_reg);
                        state_reg    <= S_CALC;
                    end else if (cmp_valid_reg && (cmp_idx_reg == last_idx)) begin
                        state_reg <= S_RESP;
                    end
                end
                S_CALC: begin
                    if (early) begin
                        res_status_reg <= ST_EARLY;
                        state_reg      <= S_RESP;
                    end else begin
                        res_status_reg <= ST_ACCEPT;
                        res_secs_reg   <= secs_diff;
                        if (secs_diff == '0) begin
                            res_speed_reg <= SPEED_MAX;
                            res_sat_reg   <= 1'b1;
                            state_reg     <= S_RESP;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // The largest dividend over the smallest nonzero time
                    // still fits the speed field, so no clipping is needed.
                    if (div_stat.done) begin
                        res_speed_reg <= SPEED_W'(quotient);
                        state_reg     <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: loaded from the pending result once it is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == S_RESP) && out_free) begin
            m_tvalid_reg <= 1'b1;
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_secs_reg   <= res_secs_reg;
            m_speed_reg  <= res_speed_reg;
            m_sat_reg    <= res_sat_reg;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - SLOT_W - SECS_W - SPEED_W - 1){1'b0}},
                       m_sat_reg, m_speed_reg, m_secs_reg, m_slot_reg};

    // The record count never exceeds the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("record count beyond table depth");

    // An entry with room left adds exactly one record.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (in_op == OP_ENTER) && !table_full)
        |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("entry did not advance the record count");

    // The divider is never running while a new event can be taken.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while block is idle");

    // The scan never reads past the newest record.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= last_idx))
        else $error("scan address beyond stored records");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the tunnel transit speed table.
//
// Every event word sent on the s_ channel is run through a predictor that
// keeps its own copy of the plate table, the entry times and the tunnel
// length. The predicted result word is queued, and each word that leaves the
// m_ channel is compared with the oldest one in that queue.
module tb_top;
    import ttst_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int DAY_LAST  = 86399;
    localparam int TIME_LAST = (1 << TIME_W) - 1;
    localparam int LEN_LAST  = (1 << LEN_W) - 1;
    localparam int LEN_TOP   = 100000;

    // Random words per idling phase, and how many of them share one length.
    localparam int RANDOM_PER_PHASE  = 530;
    localparam int ITEMS_PER_SETTING = 106;

    localparam int MAX_SHOWN   = 10;
    localparam int DRAIN_LIMIT = 200000;
    // A leave event that walks the whole table and then divides.
    localparam int TAIL_CYCLES = DEPTH + 40;

    // Bit positions of the result fields inside m_tdata.
    localparam int SECS_LSB  = SLOT_W;
    localparam int SPEED_LSB = SLOT_W + SECS_W;
    localparam int SAT_BIT   = SLOT_W + SECS_W + SPEED_W;

    // Two plates written as eight ASCII characters each.
    localparam logic [PLATE_W-1:0] PLATE_A = "TUN-0042";
    localparam logic [PLATE_W-1:0] PLATE_B = "EV 7781 ";

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [SECS_W-1:0]   secs;
        logic [SPEED_W-1:0]  speed;
        logic                sat;
    } transit_report_t;

    // All inputs of the block start at a known value.
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    // tdata: plate_key [63:0], time_seconds [80:64], zero pad.
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    // tuser: operation [0].
    logic [OP_W-1:0]      s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    // tdata: slot_index [6:0], seconds_in_tunnel [23:7],
    // speed_tenths_kmh [47:24], speed_saturated [48], zero pad.
    logic [M_TDATA_W-1:0] m_tdata;
    // tuser: status [2:0].
    logic [STATUS_W-1:0]  m_tuser;

    // Predictor state: the vehicles that have entered, in arrival order.
    logic [PLATE_W-1:0] entered_plate [DEPTH];
    logic [TIME_W-1:0]  entered_time  [DEPTH];
    int                 entered_count = 0;
    logic [LEN_W-1:0]   tunnel_len_m  = LEN_RESET;

    // Result words predicted but not yet seen on the m_ channel.
    transit_report_t reports_due [$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 20;
    int fail_count        = 0;

    tunnel_transit_speed_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // The whole run must fit well inside this time; the slowest legal run
    // takes only a fraction of it.
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("%s", msg);
        end
    endfunction

    function automatic string show_report(transit_report_t r);
        return $sformatf("status %0d slot %0d secs %0d speed %0d sat %0d",
                         r.status, r.slot, r.secs, r.speed, r.sat);
    endfunction

    // Oldest record that carries this plate, or -1 when there is none.
    function automatic int find_oldest(logic [PLATE_W-1:0] plate);
        for (int i = 0; i < entered_count; i++) begin
            if (entered_plate[i] == plate) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one event to the predictor state and returns the result word
    // that the block must answer with.
    function automatic transit_report_t track_vehicle_event(logic op,
                                                            logic [PLATE_W-1:0] plate,
                                                            logic [TIME_W-1:0] t);
        transit_report_t   rep;
        int                hit;
        logic [TIME_W-1:0] secs;
        logic [63:0]       rate;
        rep = '0;
        if (op == OP_ENTER) begin
            if (entered_count >= DEPTH) begin
                rep.status = ST_FULL;
            end else begin
                entered_plate[entered_count] = plate;
                entered_time[entered_count]  = t;
                rep.status = ST_STORED;
                rep.slot   = SLOT_W'(entered_count);
                entered_count++;
            end
            return rep;
        end
        hit = find_oldest(plate);
        if (hit < 0) begin
            rep.status = ST_UNKNOWN;
        end else if (t < entered_time[hit]) begin
            rep.status = ST_EARLY;
            rep.slot   = SLOT_W'(hit);
        end else begin
            secs       = t - entered_time[hit];
            rep.status = ST_ACCEPT;
            rep.slot   = SLOT_W'(hit);
            rep.secs   = secs;
            if (secs == '0) begin
                rep.speed = SPEED_MAX;
                rep.sat   = 1'b1;
            end else begin
                // Metres per second times 3.6 in tenths of km/h, rounded
                // to nearest with ties going up.
                rate = (64'(tunnel_len_m) * 64'd36 + 64'(secs / 2)) / 64'(secs);
                if (rate > 64'(SPEED_MAX)) begin
                    rep.speed = SPEED_MAX;
                    rep.sat   = 1'b1;
                end else begin
                    rep.speed = SPEED_W'(rate);
                end
            end
        end
        return rep;
    endfunction

    // Offers one event word, with random idle cycles first, and books its
    // predicted result once the block has taken the word.
    task automatic send_event(logic op, logic [PLATE_W-1:0] plate, logic [TIME_W-1:0] t);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({t, plate});
        do @(posedge aclk); while (!s_tready);
        reports_due.push_back(track_vehicle_event(op, plate, t));
    endtask

    // Stops sending and waits until every booked result has come back, so
    // the block is idle and the length may be changed.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] len);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tunnel_len_m = len;
    endtask

    // Mostly lengths in the normal range, with the extremes of the register
    // mixed in, zero included.
    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(9))
            0: return LEN_W'(1);
            1: return LEN_W'(LEN_TOP);
            2: return LEN_W'(LEN_LAST);
            3: return '0;
            default: return LEN_W'($urandom_range(LEN_TOP, 1));
        endcase
    endfunction

    // One random event. Most leave events name a plate that is in the table,
    // with an exit time placed relative to its oldest entry so that zero,
    // short, long and backwards transits all occur. The rest are entries,
    // some of them repeating a plate, and leave events for unknown plates.
    task automatic send_random_event();
        int                 pick;
        int                 base;
        int                 when;
        logic               op;
        logic [PLATE_W-1:0] plate;
        logic [TIME_W-1:0]  t;
        pick  = $urandom_range(99);
        plate = {$urandom, $urandom};
        case ($urandom_range(31))
            0: plate = '0;
            1: plate = '1;
            default: ;
        endcase
        t = TIME_W'($urandom_range(DAY_LAST));
        if ($urandom_range(9) == 0) begin
            t = TIME_W'($urandom_range(TIME_LAST));
        end
        if (pick < 15) begin
            op = OP_ENTER;
            if (entered_count != 0 && $urandom_range(4) == 0) begin
                plate = entered_plate[$urandom_range(entered_count - 1)];
            end
        end else if (pick < 90 && entered_count != 0) begin
            op    = OP_LEAVE;
            plate = entered_plate[$urandom_range(entered_count - 1)];
            base  = int'(entered_time[find_oldest(plate)]);
            case ($urandom_range(9))
                0: when = (base != 0) ? int'($urandom_range(base - 1)) : base;
                1: when = base;
                2, 3, 4, 5, 6: when = base + int'($urandom_range(900, 1));
                default: when = int'($urandom_range(TIME_LAST, base));
            endcase
            if (when > TIME_LAST) begin
                when = TIME_LAST;
            end
            t = TIME_W'(when);
        end else begin
            op = OP_LEAVE;
        end
        send_event(op, plate, t);
    endtask

    // Hand-picked events at the reset length of 1000 m.
    task automatic test_directed_events();
        // A leave event on an empty table finds nothing.
        send_event(OP_LEAVE, '0, '0);
        send_event(OP_ENTER, '0, '0);
        send_event(OP_ENTER, '1, TIME_W'(DAY_LAST));
        send_event(OP_ENTER, PLATE_A, TIME_W'(1000));
        // Zero transit time saturates the speed.
        send_event(OP_LEAVE, '0, '0);
        // An exit one second before the entry is refused.
        send_event(OP_LEAVE, '1, TIME_W'(DAY_LAST - 1));
        send_event(OP_LEAVE, PLATE_A, TIME_W'(1060));
        // 36000 / 64 is exactly 562.5, which has to round up.
        send_event(OP_LEAVE, PLATE_A, TIME_W'(1064));
        send_event(OP_LEAVE, PLATE_A, TIME_W'(1001));
        // A second record of the same plate; the exit still matches the
        // oldest one.
        send_event(OP_ENTER, PLATE_A, TIME_W'(5000));
        send_event(OP_LEAVE, PLATE_A, TIME_W'(5000));
        // Times past the end of the day are used as they are.
        send_event(OP_ENTER, PLATE_B, TIME_W'(65536));
        send_event(OP_LEAVE, PLATE_B, TIME_W'(TIME_LAST));
        send_event(OP_LEAVE, '0, TIME_W'(TIME_LAST));
        send_event(OP_LEAVE, 64'h5A5A_C3C3_0F0F_9696, TIME_W'(300));
        wait_idle();
    endtask

    // The length register at zero, one, its largest value and 100000.
    task automatic test_length_extremes();
        write_length('0);
        send_event(OP_LEAVE, PLATE_A, TIME_W'(1100));
        send_event(OP_LEAVE, '0, '0);
        wait_idle();
        write_length(LEN_W'(1));
        send_event(OP_LEAVE, PLATE_A, TIME_W'(1003));
        send_event(OP_LEAVE, PLATE_A, TIME_W'(1072));
        wait_idle();
        write_length(LEN_W'(LEN_LAST));
        send_event(OP_LEAVE, '0, TIME_W'(1));
        wait_idle();
        write_length(LEN_W'(LEN_TOP));
        send_event(OP_LEAVE, '0, TIME_W'(2));
        wait_idle();
    endtask

    // Random traffic under one idling pattern. Every ITEMS_PER_SETTING words the
    // sender holds off until all results are back and a new length is set.
    task automatic test_random_phase(int send_pct, int recv_pct);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % ITEMS_PER_SETTING == 0) begin
                wait_idle();
                write_length(pick_length());
            end
            send_random_event();
        end
    endtask

    // The receiver drops tready at random; the rate is set per phase.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Every result word that the receiver takes is compared with the oldest
    // prediction. A word with nothing booked is a failure of its own.
    always @(posedge aclk) begin : check_reports
        transit_report_t got;
        transit_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.slot   = m_tdata[0 +: SLOT_W];
            got.secs   = m_tdata[SECS_LSB +: SECS_W];
            got.speed  = m_tdata[SPEED_LSB +: SPEED_W];
            got.sat    = m_tdata[SAT_BIT];
            if (reports_due.size() == 0) begin
                note_failure($sformatf("unexpected result word: %s", show_report(got)));
            end else begin
                want = reports_due.pop_front();
                if (got != want) begin
                    note_failure($sformatf("result mismatch: expected %s, got %s",
                                           show_report(want), show_report(got)));
                end
            end
        end
    end

    initial begin
        // Reset is held from the start and released between edges.
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_events();
        test_length_extremes();
        test_random_phase(30, 54);
        test_random_phase(54, 30);
        test_random_phase(0, 0);

        // Drain: wait for every outstanding result, then long enough for a
        // full table walk plus the divide, so that any stray word shows up.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && reports_due.size() != 0; c++) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (reports_due.size() != 0) begin
            note_failure($sformatf("%0d result words never arrived", reports_due.size()));
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
